// ===== sv/bgm_pkg.sv =====
// Package for the bracket group matcher: token kind codes and fixed field widths.
// No dependencies; used by bracket_group_matcher_unit.
package bgm_pkg;

  localparam int KIND_W  = 3;   // token_kind width
  localparam int POS_W   = 32;  // begin / end byte offsets
  localparam int DEPTH_W = 5;   // stack_depth output width
  localparam int OPK_W   = 2;   // stored opener kind

  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LSQUARE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LCURLY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RSQUARE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RCURLY  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 3'd6;

  // distance from a closer code to the code of its opener
  localparam logic [KIND_W-1:0] CLOSER_OFFSET = 3'd3;

endpackage

// ===== sv/bracket_group_matcher_unit.sv =====
// Bracket group matcher: opener stack held in a synchronous RAM, searched top-down per closer.
// Depends on bgm_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------------
//  in      | in_valid/in_stall  | token_kind, token_begin, token_end
//  out     | out_valid/out_stall| top_match, group_found, group_begin, group_end,
//          |                    | stack_depth, overflow
//
// Openers, non-bracket tokens and closers on an empty stack finish in the accept cycle;
// the result is registered. A closer on a non-empty stack reads the stack RAM one entry per
// cycle from the top via the single registered read port until a match or the bottom entry.
// One transaction in flight; in_stall is high while a search runs or a result is held.
// rst is synchronous, active high; clears count, pending pop and handshake state.
// Stack RAM contents are not reset: only entries below the count are ever used.
module bracket_group_matcher_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bgm_pkg::KIND_W-1:0]    token_kind,
  input  logic [bgm_pkg::POS_W-1:0]     token_begin,
  input  logic [bgm_pkg::POS_W-1:0]     token_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          top_match,
  output logic                          group_found,
  output logic [bgm_pkg::POS_W-1:0]     group_begin,
  output logic [bgm_pkg::POS_W-1:0]     group_end,
  output logic [bgm_pkg::DEPTH_W-1:0]   stack_depth,
  output logic                          overflow
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int ENT_W  = bgm_pkg::OPK_W + bgm_pkg::POS_W;

  typedef enum logic {IDLE, SEARCH} state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic                       pending_pop;
  logic [ADDR_W-1:0]          idx;
  logic                       first;
  logic [bgm_pkg::OPK_W-1:0]  want;
  logic [bgm_pkg::POS_W-1:0]  end_hold;

  logic [ENT_W-1:0]           stack_mem [STACK_DEPTH];
  logic [ENT_W-1:0]           rd_data;
  logic [ADDR_W-1:0]          rd_addr;

  logic                       in_take;
  logic                       is_opener;
  logic                       is_closer;
  logic [CNT_W-1:0]           cnt_eff;
  logic [CNT_W-1:0]           cnt_next;
  logic                       push_ok;
  logic [CNT_W+bgm_pkg::DEPTH_W-1:0] depth_ext;
  logic [bgm_pkg::OPK_W-1:0]  rd_kind;
  logic [bgm_pkg::POS_W-1:0]  rd_begin;
  logic                       hit;
  logic                       search_done;
  logic                       direct_done;
  logic [bgm_pkg::KIND_W-1:0] want_full;

  assign in_stall  = (state != IDLE) || (out_valid && out_stall);
  assign in_take   = in_valid && !in_stall;

  assign is_opener = (token_kind == bgm_pkg::KIND_LSQUARE) ||
                     (token_kind == bgm_pkg::KIND_LCURLY)  ||
                     (token_kind == bgm_pkg::KIND_LPAREN);
  assign is_closer = (token_kind == bgm_pkg::KIND_RSQUARE) ||
                     (token_kind == bgm_pkg::KIND_RCURLY)  ||
                     (token_kind == bgm_pkg::KIND_RPAREN);
  assign want_full = token_kind - bgm_pkg::CLOSER_OFFSET;

  // deferred pop from the previous closer lands at the start of this token
  assign cnt_eff = (pending_pop && (count != '0)) ? count - CNT_W'(1) : count;
  assign push_ok = is_opener && (cnt_eff < CNT_W'(STACK_DEPTH));

  // transaction that completes without a search
  assign direct_done = in_take && !(is_closer && (cnt_eff != '0));

  always_comb begin
    cnt_next = count;
    if (state == IDLE) begin
      cnt_next = push_ok ? cnt_eff + CNT_W'(1) : cnt_eff;
    end
  end

  assign depth_ext = {{bgm_pkg::DEPTH_W{1'b0}}, cnt_next};

  assign rd_kind  = rd_data[ENT_W-1 -: bgm_pkg::OPK_W];
  assign rd_begin = rd_data[bgm_pkg::POS_W-1:0];
  assign hit      = (rd_kind == want);
  assign search_done = (state == SEARCH) && (hit || (idx == '0));

  // top entry on accept, then walk down one entry per cycle
  always_comb begin
    if (state == IDLE) begin
      rd_addr = ADDR_W'(cnt_eff - CNT_W'(1));
    end else begin
      rd_addr = idx - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && push_ok) begin
      stack_mem[cnt_eff[ADDR_W-1:0]] <= {token_kind[bgm_pkg::OPK_W-1:0], token_begin};
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      count       <= '0;
      pending_pop <= 1'b0;
      out_valid   <= 1'b0;
      first       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !direct_done) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_take) begin
            count       <= cnt_next;
            pending_pop <= 1'b0;
            top_match   <= 1'b0;
            group_found <= 1'b0;
            group_begin <= '0;
            group_end   <= '0;
            stack_depth <= depth_ext[bgm_pkg::DEPTH_W-1:0];
            overflow    <= is_opener && !push_ok;
            want        <= want_full[bgm_pkg::OPK_W-1:0];
            end_hold    <= token_end;
            idx         <= rd_addr;
            first       <= 1'b1;
            if (is_closer && (cnt_eff != '0)) begin
              state <= SEARCH;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        SEARCH: begin
          first <= 1'b0;
          if (first && hit) begin
            top_match   <= 1'b1;
            pending_pop <= 1'b1;
          end
          if (hit) begin
            group_found <= 1'b1;
            group_begin <= rd_begin;
            group_end   <= end_hold;
          end
          if (search_done) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end else begin
            idx <= idx - ADDR_W'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // count stays within the stack
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // a search ends only with the result register free
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    search_done |-> !out_valid)
    else $error("search finished over a held result");

  // a top match is always a found group
  a_top_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && top_match) |-> group_found)
    else $error("top match without group");

  // a pop is deferred only over a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pending_pop |-> (count != '0))
    else $error("pending pop on empty stack");

  // a dropped opener means the stack was full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (count == CNT_W'(STACK_DEPTH)))
    else $error("overflow with room left");

endmodule

// ===== dv/bracket_group_matcher_unit_tb.sv =====
// Self-checking testbench for bracket_group_matcher_unit: directed and random token streams,
// with an in-bench opener stack that predicts every group result.
// Depends on bgm_pkg and bracket_group_matcher_unit.
`timescale 1ns / 100ps

module bracket_group_matcher_unit_tb;

  localparam int STACK_DEPTH    = 16;
  localparam int RANDOM_TOKENS  = 800;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_TOKEN  = 400;
  localparam int DRAIN_AT_TOKEN = 600;
  localparam int STUCK_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 2 * STACK_DEPTH + 16;
  // unused kind code, handled as other
  localparam logic [bgm_pkg::KIND_W-1:0] KIND_SPARE = 3'd7;

  typedef struct {
    logic [bgm_pkg::KIND_W-1:0] kind;
    logic [bgm_pkg::POS_W-1:0]  tbeg;
    logic [bgm_pkg::POS_W-1:0]  tend;
    int unsigned                gap;
    bit                         drain;
  } token_item_t;

  typedef struct packed {
    logic                        top_match;
    logic                        group_found;
    logic [bgm_pkg::POS_W-1:0]   group_begin;
    logic [bgm_pkg::POS_W-1:0]   group_end;
    logic [bgm_pkg::DEPTH_W-1:0] stack_depth;
    logic                        overflow;
  } group_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [bgm_pkg::KIND_W-1:0]  token_kind = bgm_pkg::KIND_OTHER;
  logic [bgm_pkg::POS_W-1:0]   token_begin = '0;
  logic [bgm_pkg::POS_W-1:0]   token_end = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        top_match;
  logic                        group_found;
  logic [bgm_pkg::POS_W-1:0]   group_begin;
  logic [bgm_pkg::POS_W-1:0]   group_end;
  logic [bgm_pkg::DEPTH_W-1:0] stack_depth;
  logic                        overflow;

  token_item_t   pending_tokens[$];
  group_result_t expected_groups[$];

  // predicted opener stack
  logic [bgm_pkg::OPK_W-1:0] open_kind [STACK_DEPTH];
  logic [bgm_pkg::POS_W-1:0] open_begin [STACK_DEPTH];
  int unsigned               open_count = 0;
  bit                        pop_due = 1'b0;

  // generator's view of the open brackets, used only to shape the stream
  logic [bgm_pkg::KIND_W-1:0] gen_open[$];

  int unsigned tokens_accepted = 0;
  int unsigned groups_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_wait = 0;
  int unsigned stuck_cycles = 0;
  logic        long_hold = 1'b0;
  bit          accepted_now;

  bracket_group_matcher_unit #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .token_kind(token_kind), .token_begin(token_begin), .token_end(token_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_match(top_match), .group_found(group_found),
    .group_begin(group_begin), .group_end(group_end),
    .stack_depth(stack_depth), .overflow(overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_opener(input logic [bgm_pkg::KIND_W-1:0] kind);
    return kind == bgm_pkg::KIND_LSQUARE || kind == bgm_pkg::KIND_LCURLY ||
           kind == bgm_pkg::KIND_LPAREN;
  endfunction

  function automatic bit is_closer(input logic [bgm_pkg::KIND_W-1:0] kind);
    return kind == bgm_pkg::KIND_RSQUARE || kind == bgm_pkg::KIND_RCURLY ||
           kind == bgm_pkg::KIND_RPAREN;
  endfunction

  // Work out the group result of one accepted token and update the opener stack.
  function automatic void predict_group(input logic [bgm_pkg::KIND_W-1:0] kind,
                                        input logic [bgm_pkg::POS_W-1:0] tbeg,
                                        input logic [bgm_pkg::POS_W-1:0] tend);
    group_result_t             r;
    logic [bgm_pkg::OPK_W-1:0] want;
    r = '0;
    if (pop_due) begin
      if (open_count > 0) open_count--;
      pop_due = 1'b0;
    end
    if (is_opener(kind)) begin
      if (open_count < STACK_DEPTH) begin
        open_kind[open_count]  = kind[bgm_pkg::OPK_W-1:0];
        open_begin[open_count] = tbeg;
        open_count++;
      end else begin
        r.overflow = 1'b1;
      end
    end else if (is_closer(kind)) begin
      want = bgm_pkg::OPK_W'(kind - bgm_pkg::CLOSER_OFFSET);
      if (open_count > 0 && open_kind[open_count-1] == want) begin
        r.top_match = 1'b1;
        pop_due = 1'b1;
      end
      for (int i = open_count; i > 0; i--) begin
        if (open_kind[i-1] == want) begin
          r.group_found = 1'b1;
          r.group_begin = open_begin[i-1];
          r.group_end   = tend;
          break;
        end
      end
    end
    r.stack_depth = bgm_pkg::DEPTH_W'(open_count);
    expected_groups.push_back(r);
  endfunction

  task automatic add_token(input logic [bgm_pkg::KIND_W-1:0] kind,
                           input logic [bgm_pkg::POS_W-1:0] tbeg,
                           input logic [bgm_pkg::POS_W-1:0] tend, input int unsigned gap,
                           input bit drain);
    token_item_t t;
    t.kind = kind;
    t.tbeg = tbeg;
    t.tend = tend;
    t.gap = gap;
    t.drain = drain;
    pending_tokens.push_back(t);
    if (is_opener(kind)) begin
      if (gen_open.size() < STACK_DEPTH) gen_open.push_back(kind);
    end else if (is_closer(kind)) begin
      if (gen_open.size() > 0 && gen_open[$] + bgm_pkg::CLOSER_OFFSET == kind)
        gen_open.delete(gen_open.size() - 1);
    end
  endtask

  task automatic check_group();
    group_result_t e;
    if (expected_groups.size() == 0) begin
      $error("group result with no pending expectation");
      mismatches++;
    end else begin
      e = expected_groups.pop_front();
      if (top_match !== e.top_match) begin
        $error("top_match: expected %0d, got %0d", e.top_match, top_match);
        mismatches++;
      end
      if (group_found !== e.group_found) begin
        $error("group_found: expected %0d, got %0d", e.group_found, group_found);
        mismatches++;
      end
      if (group_begin !== e.group_begin) begin
        $error("group_begin: expected %h, got %h", e.group_begin, group_begin);
        mismatches++;
      end
      if (group_end !== e.group_end) begin
        $error("group_end: expected %h, got %h", e.group_end, group_end);
        mismatches++;
      end
      if (stack_depth !== e.stack_depth) begin
        $error("stack_depth: expected %0d, got %0d", e.stack_depth, stack_depth);
        mismatches++;
      end
      if (overflow !== e.overflow) begin
        $error("overflow: expected %0d, got %0d", e.overflow, overflow);
        mismatches++;
      end
    end
  endtask

  // stimulus
  initial begin
    int unsigned                roll;
    int unsigned                gap;
    logic [bgm_pkg::KIND_W-1:0] kind;
    // closer on an empty stack, then a closer with no paired opener
    add_token(bgm_pkg::KIND_RPAREN, '0, '1, $urandom_range(0, 10), 1'b0);
    add_token(bgm_pkg::KIND_LSQUARE, '1, '0, $urandom_range(0, 10), 1'b0);
    add_token(bgm_pkg::KIND_RCURLY, '0, '1, $urandom_range(0, 10), 1'b0);
    // top match; its pop is deferred to the following token
    add_token(bgm_pkg::KIND_RSQUARE, $urandom, '1, $urandom_range(0, 10), 1'b0);
    add_token(bgm_pkg::KIND_OTHER, '1, '1, $urandom_range(0, 10), 1'b0);
    add_token(KIND_SPARE, '1, '0, $urandom_range(0, 10), 1'b0);
    // fill the stack, then one opener too many
    for (int i = 0; i < STACK_DEPTH; i++) begin
      add_token(bgm_pkg::KIND_LSQUARE + bgm_pkg::KIND_W'(i % 3),
                (i == 0) ? '0 : (i == STACK_DEPTH - 1) ? '1 : $urandom,
                $urandom, $urandom_range(0, 10), 1'b0);
    end
    add_token(bgm_pkg::KIND_LCURLY, $urandom, $urandom, $urandom_range(0, 10), 1'b0);
    // top match, then a curly found below the top
    add_token(bgm_pkg::KIND_RSQUARE, $urandom, '1, $urandom_range(0, 10), 1'b0);
    add_token(bgm_pkg::KIND_RCURLY, $urandom, $urandom, $urandom_range(0, 10), 1'b0);

    for (int n = 0; n < RANDOM_TOKENS; n++) begin
      gap = (n % 128 < 32 || (n >= 360 && n < 440)) ? 0 : $urandom_range(0, 10);
      if (n % 150 == 75) begin
        // nest to full depth and overflow a couple of times
        while (gen_open.size() < STACK_DEPTH) begin
          add_token(bgm_pkg::KIND_LSQUARE + bgm_pkg::KIND_W'($urandom_range(0, 2)),
                    $urandom, $urandom, gap, 1'b0);
        end
        repeat (2) begin
          add_token(bgm_pkg::KIND_LSQUARE + bgm_pkg::KIND_W'($urandom_range(0, 2)),
                    $urandom, $urandom, gap, 1'b0);
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) kind = bgm_pkg::KIND_W'($urandom_range(0, 7));
      else if (roll < 46 || gen_open.size() == 0 && roll < 70)
        kind = bgm_pkg::KIND_LSQUARE + bgm_pkg::KIND_W'($urandom_range(0, 2));
      else if (roll < 88 && gen_open.size() > 0)
        kind = gen_open[$] + bgm_pkg::CLOSER_OFFSET;
      else kind = bgm_pkg::KIND_RSQUARE + bgm_pkg::KIND_W'($urandom_range(0, 2));
      add_token(kind, $urandom, $urandom, gap, (n == DRAIN_AT_TOKEN));
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_idle = 0;
    end else begin
      accepted_now = in_valid && !in_stall;
      if (accepted_now) begin
        predict_group(token_kind, token_begin, token_end);
        void'(pending_tokens.pop_front());
        tokens_accepted <= tokens_accepted + 1;
        send_idle = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_tokens.size() > 0 && send_idle >= pending_tokens[0].gap &&
            !(pending_tokens[0].drain &&
              (accepted_now || tokens_accepted != groups_seen))) begin
          in_valid    <= 1'b1;
          token_kind  <= pending_tokens[0].kind;
          token_begin <= pending_tokens[0].tbeg;
          token_end   <= pending_tokens[0].tend;
        end else begin
          in_valid <= 1'b0;
          if (pending_tokens.size() > 0) send_idle++;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_group();
        groups_seen <= groups_seen + 1;
        recv_wait = (groups_seen % 128 < 40) ? 0 : $urandom_range(0, 10);
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering back-to-back
  initial begin
    while (tokens_accepted < HOLD_AT_TOKEN) @(negedge clk);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_tokens.size() > 0 || expected_groups.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
